### rtl/hsvrgb_pkg.sv
// Shared types, constants and helpers for the HSV to RGB converter.
// No dependencies; imported by every module of the block.
package hsvrgb_pkg;

    localparam int FRAC_BITS = 15;
    localparam int Q_BITS    = 20;   // quotient bits, one per divider cell
    localparam int NUM_CELLS = Q_BITS;

    localparam logic [16:0] HUE_TURN  = 17'd25736;
    localparam logic [15:0] ONE_Q15   = 16'd32768;
    localparam logic [18:0] OUT_MAX   = 19'd458752;
    localparam logic [20:0] RECIP     = 21'd1335084;  // floor(2^32 / 3217)
    localparam logic [11:0] HUE_DIV   = 12'd3217;     // HUE_TURN / 8
    localparam logic [15:0] LUMA_WR   = 16'd13933;
    localparam logic [15:0] LUMA_WG   = 16'd46871;
    localparam logic [15:0] LUMA_WB   = 16'd4732;
    localparam logic [15:0] THR_RESET = 16'd33;

    // configuration register index, taken from paddr[2]
    typedef enum logic {
        REG_NORM_EN  = 1'b0,
        REG_LUMA_THR = 1'b1
    } reg_idx_t;

    // one color channel as it travels through the divider row
    typedef struct packed {
        logic        ovf;   // quotient does not fit in Q_BITS
        logic [31:0] rh;    // partial remainder
        logic [19:0] lo;    // dividend bits still to shift in
        logic [19:0] q;     // quotient bits so far
    } lane_t;

    typedef struct packed {
        logic [31:0]     div;
        lane_t [2:0]     lane;
    } cell_data_t;

    function automatic logic [15:0] clamp_unit(input logic [15:0] raw);
        clamp_unit = (raw > ONE_Q15) ? ONE_Q15 : raw;
    endfunction

    function automatic logic [18:0] sat_out(input lane_t ln);
        if (ln.ovf || ln.q > {1'b0, OUT_MAX}) begin
            sat_out = OUT_MAX;
        end else begin
            sat_out = ln.q[18:0];
        end
    endfunction

endpackage

### rtl/hsvrgb_front.sv
// Front pipeline: hue wrap and sector split, chroma, RGB build, luminance
// and dividend setup for the divider row. Depends on hsvrgb_pkg.
module hsvrgb_front import hsvrgb_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [15:0]      hue,
    input  logic [15:0]      saturation,
    input  logic [15:0]      brightness,
    input  logic             norm_en,
    input  logic [15:0]      luma_thr,
    output logic             out_valid,
    input  logic             out_ready,
    output cell_data_t       out_data
);

    logic [6:0] vld_reg;
    logic [7:0] rdy;

    // per-stage ready: a stage loads when empty or when its successor moves
    always_comb begin
        rdy[7] = out_ready;
        for (int k = 6; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < 7; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: wrap hue, pick sector, chroma
    logic signed [16:0] hw;
    logic [17:0] h6;
    logic [2:0]  sec_c;
    logic [17:0] base;
    logic [15:0] s_c, v_c;
    logic [32:0] cprod;
    logic [2:0]  s1_sec_reg;
    logic [14:0] s1_r6_reg;
    logic [15:0] s1_c_reg, s1_v_reg;

    always_comb begin
        hw = {hue[15], hue};
        if (hw < 0) hw = hw + $signed(HUE_TURN);
        if (hw < 0) hw = hw + $signed(HUE_TURN);
        if (hw >= $signed(HUE_TURN)) hw = hw - $signed(HUE_TURN);
        h6 = 18'(hw[15:0]) * 18'd6;
        sec_c = 3'd0;
        for (int k = 1; k < 6; k++) begin
            if (h6 >= 18'(HUE_TURN) * 18'(k)) sec_c = 3'(k);
        end
        base  = 18'(HUE_TURN) * 18'(sec_c);
        s_c   = clamp_unit(saturation);
        v_c   = clamp_unit(brightness);
        cprod = 33'(v_c * s_c) + 33'd16384;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s1_sec_reg <= sec_c;
            s1_r6_reg  <= 15'(h6 - base);
            s1_c_reg   <= cprod[30:15];
            s1_v_reg   <= v_c;
        end
    end

    // stage 2: fraction estimate by reciprocal multiply
    logic [26:0] n1;
    logic [47:0] qprod;
    logic [2:0]  s2_sec_reg;
    logic [26:0] s2_n_reg;
    logic [15:0] s2_qe_reg, s2_c_reg, s2_v_reg;

    assign n1    = {s1_r6_reg, 12'd0};
    assign qprod = 48'(n1) * 48'(RECIP);

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            s2_sec_reg <= s1_sec_reg;
            s2_n_reg   <= n1;
            s2_qe_reg  <= qprod[47:32];
            s2_c_reg   <= s1_c_reg;
            s2_v_reg   <= s1_v_reg;
        end
    end

    // stage 3: one-step correction of the estimate
    logic [27:0] rem3;
    logic [15:0] frac3;
    logic [2:0]  s3_sec_reg;
    logic [14:0] s3_frac_reg;
    logic [15:0] s3_c_reg, s3_v_reg;

    always_comb begin
        rem3  = 28'(s2_n_reg) - 28'(s2_qe_reg) * 28'(HUE_DIV);
        frac3 = (rem3 >= 28'(HUE_DIV)) ? s2_qe_reg + 16'd1 : s2_qe_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            s3_sec_reg  <= s2_sec_reg;
            s3_frac_reg <= frac3[14:0];
            s3_c_reg    <= s2_c_reg;
            s3_v_reg    <= s2_v_reg;
        end
    end

    // stage 4: middle channel and sector mapping plus offset
    logic [15:0] w4, x4, m4;
    logic [32:0] xprod;
    logic [15:0] r4, g4, b4;
    logic [15:0] s4_r_reg, s4_g_reg, s4_b_reg, s4_v_reg;

    always_comb begin
        w4 = s3_sec_reg[0] ? ONE_Q15 - 16'(s3_frac_reg) : 16'(s3_frac_reg);
        xprod = 33'(s3_c_reg * w4) + 33'd16384;
        x4 = xprod[30:15];
        m4 = s3_v_reg - s3_c_reg;
        case (s3_sec_reg)
            3'd0:    begin r4 = s3_c_reg; g4 = x4;       b4 = '0;       end
            3'd1:    begin r4 = x4;       g4 = s3_c_reg; b4 = '0;       end
            3'd2:    begin r4 = '0;       g4 = s3_c_reg; b4 = x4;       end
            3'd3:    begin r4 = '0;       g4 = x4;       b4 = s3_c_reg; end
            3'd4:    begin r4 = x4;       g4 = '0;       b4 = s3_c_reg; end
            default: begin r4 = s3_c_reg; g4 = '0;       b4 = x4;       end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            s4_r_reg <= r4 + m4;
            s4_g_reg <= g4 + m4;
            s4_b_reg <= b4 + m4;
            s4_v_reg <= s3_v_reg;
        end
    end

    // stage 5: weighted luminance terms
    logic [31:0] s5_pr_reg, s5_pg_reg, s5_pb_reg;
    logic [15:0] s5_r_reg, s5_g_reg, s5_b_reg, s5_v_reg;

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            s5_pr_reg <= s4_r_reg * LUMA_WR;
            s5_pg_reg <= s4_g_reg * LUMA_WG;
            s5_pb_reg <= s4_b_reg * LUMA_WB;
            s5_r_reg  <= s4_r_reg;
            s5_g_reg  <= s4_g_reg;
            s5_b_reg  <= s4_b_reg;
            s5_v_reg  <= s4_v_reg;
        end
    end

    // stage 6: luminance sum, threshold test, numerators
    logic [31:0] lum6;
    logic [31:0] s6_lum_reg;
    logic        s6_norm_reg;
    logic [31:0] s6_num_reg [3];
    logic [15:0] s6_ch_reg [3];

    assign lum6 = s5_pr_reg + s5_pg_reg + s5_pb_reg;

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            s6_lum_reg    <= lum6;
            s6_norm_reg   <= norm_en && (lum6 > {luma_thr, 16'd0});
            s6_num_reg[0] <= s5_r_reg * s5_v_reg;
            s6_num_reg[1] <= s5_g_reg * s5_v_reg;
            s6_num_reg[2] <= s5_b_reg * s5_v_reg;
            s6_ch_reg[0]  <= s5_r_reg;
            s6_ch_reg[1]  <= s5_g_reg;
            s6_ch_reg[2]  <= s5_b_reg;
        end
    end

    // stage 7: dividend setup and overflow test; plain path divides by one
    cell_data_t d7;
    logic [47:0] dd [3];

    always_comb begin
        d7.div = s6_norm_reg ? s6_lum_reg : 32'd1;
        for (int i = 0; i < 3; i++) begin
            dd[i] = s6_norm_reg ? ({s6_num_reg[i], 16'd0} + 48'(s6_lum_reg >> 1))
                                : 48'(s6_ch_reg[i]);
            d7.lane[i].ovf = {4'd0, dd[i]} >= {d7.div, 20'd0};
            d7.lane[i].rh  = 32'(dd[i][47:20]);
            d7.lane[i].lo  = dd[i][19:0];
            d7.lane[i].q   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            out_data <= d7;
        end
    end

endmodule

### rtl/hsvrgb_cell.sv
// One divider cell: one restoring quotient bit for each of three channels.
// Depends on hsvrgb_pkg.
module hsvrgb_cell import hsvrgb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  cell_data_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output cell_data_t out_data
);

    logic       vld_reg;
    cell_data_t data_next;
    logic [32:0] t;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;

    // shift in next dividend bit, subtract divisor when it fits
    always_comb begin
        data_next = in_data;
        for (int i = 0; i < 3; i++) begin
            t = {in_data.lane[i].rh, in_data.lane[i].lo[19]};
            if (t >= 33'(in_data.div)) begin
                data_next.lane[i].rh = 32'(t - 33'(in_data.div));
                data_next.lane[i].q  = {in_data.lane[i].q[18:0], 1'b1};
            end else begin
                data_next.lane[i].rh = t[31:0];
                data_next.lane[i].q  = {in_data.lane[i].q[18:0], 1'b0};
            end
            data_next.lane[i].lo = {in_data.lane[i].lo[18:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            out_data <= data_next;
        end
    end

endmodule

### rtl/hsv_to_rgb_luma_normalized_top.sv
// HSV to RGB converter with optional Rec.709 luminance normalization.
// Pipeline: 7 front stages, 20 divider cells, 1 output register.
// Throughput: one beat per cycle unless stalled by m_ready; set by the row of
// divider cells, each cell producing one quotient bit for all three channels.
// Reset: synchronous active-low aresetn clears all valid flags and loads
// normalize_enable = 1 and luma_threshold = 33. Depends on hsvrgb_pkg.
module hsv_to_rgb_luma_normalized_top import hsvrgb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_hue,
    input  logic [15:0] s_saturation,
    input  logic [15:0] s_brightness,
    // result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [18:0] m_red,
    output logic [18:0] m_green,
    output logic [18:0] m_blue
);

    logic        norm_en_reg;
    logic [15:0] luma_thr_reg;
    reg_idx_t    ridx;

    assign pready = 1'b1;
    assign ridx   = reg_idx_t'(paddr[2]);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_en_reg  <= 1'b1;
            luma_thr_reg <= THR_RESET;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                REG_NORM_EN:  norm_en_reg  <= pwdata[0];
                REG_LUMA_THR: luma_thr_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            REG_NORM_EN:  prdata = {31'd0, norm_en_reg};
            REG_LUMA_THR: prdata = {16'd0, luma_thr_reg};
            default:      prdata = '0;
        endcase
    end

    // front pipeline
    logic       cv [NUM_CELLS+1];
    logic       cr [NUM_CELLS+1];
    cell_data_t cd [NUM_CELLS+1];

    hsvrgb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .hue       (s_hue),
        .saturation(s_saturation),
        .brightness(s_brightness),
        .norm_en   (norm_en_reg),
        .luma_thr  (luma_thr_reg),
        .out_valid (cv[0]),
        .out_ready (cr[0]),
        .out_data  (cd[0])
    );

    // divider row
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        hsvrgb_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (cv[k]),
            .in_ready (cr[k]),
            .in_data  (cd[k]),
            .out_valid(cv[k+1]),
            .out_ready(cr[k+1]),
            .out_data (cd[k+1])
        );
    end

    // output register with saturation
    logic m_valid_reg;
    logic [18:0] red_reg, green_reg, blue_reg;

    assign cr[NUM_CELLS] = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cr[NUM_CELLS]) begin
            m_valid_reg <= cv[NUM_CELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (cr[NUM_CELLS]) begin
            red_reg   <= sat_out(cd[NUM_CELLS].lane[0]);
            green_reg <= sat_out(cd[NUM_CELLS].lane[1]);
            blue_reg  <= sat_out(cd[NUM_CELLS].lane[2]);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = red_reg;
    assign m_green = green_reg;
    assign m_blue  = blue_reg;

`ifndef NO_ASSERTIONS
    // input only stalls when the result register is blocked
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without output backpressure");

    // results never exceed the saturation level
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_red <= OUT_MAX && m_green <= OUT_MAX && m_blue <= OUT_MAX))
        else $error("result above saturation level");

    // reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");
`endif

endmodule

### tb/tb_hsv_to_rgb_luma_normalized_top.sv
// Testbench for the HSV to RGB converter with luminance normalization.
// Drives color beats and APB writes, checks results against a local predictor.
// Depends on hsvrgb_pkg and hsv_to_rgb_luma_normalized_top.
`timescale 1ns / 100ps

module tb_hsv_to_rgb_luma_normalized_top import hsvrgb_pkg::*;;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid, s_ready;
    logic [15:0] s_hue, s_saturation, s_brightness;
    logic        m_valid, m_ready;
    logic [18:0] m_red, m_green, m_blue;

    typedef struct packed {
        logic [18:0] r;
        logic [18:0] g;
        logic [18:0] b;
    } rgb_t;

    // directed row: input, plus a typed-in result when typed is set
    typedef struct {
        logic [15:0] hue;
        logic [15:0] sat;
        logic [15:0] val;
        bit          typed;
        rgb_t        rgb;
    } row_t;

    rgb_t        rgb_expected_q[$];
    int          errors;
    logic        norm_en_model;
    logic [15:0] thr_model;
    bit          hold_off;

    hsv_to_rgb_luma_normalized_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_hue(s_hue),
        .s_saturation(s_saturation), .s_brightness(s_brightness),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_red(m_red), .m_green(m_green), .m_blue(m_blue)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [63:0] sat19(input logic [63:0] v);
        return (v > 64'(OUT_MAX)) ? 64'(OUT_MAX) : v;
    endfunction

    // predicted color for one beat under the current register settings
    function automatic rgb_t hsv_convert(input logic [15:0] hue_in,
                                         input logic [15:0] s_in,
                                         input logic [15:0] v_in);
        int          h;
        logic [63:0] s, v, hp, sector, frac, c, w, x, m, r, g, b, lum, half;
        rgb_t        res;
        h = $signed(hue_in);
        s = (s_in > 16'd32768) ? 64'd32768 : 64'(s_in);
        v = (v_in > 16'd32768) ? 64'd32768 : 64'(v_in);
        h = h % 25736;
        if (h < 0) h += 25736;
        hp = ((64'(h) * 6) << 15) / 64'd25736;
        sector = hp >> 15;
        frac = hp & 64'h7FFF;
        c = (v * s + 64'd16384) >> 15;
        w = sector[0] ? (64'd32768 - frac) : frac;
        x = (c * w + 64'd16384) >> 15;
        case (sector)
            0: begin r = c; g = x; b = 0; end
            1: begin r = x; g = c; b = 0; end
            2: begin r = 0; g = c; b = x; end
            3: begin r = 0; g = x; b = c; end
            4: begin r = x; g = 0; b = c; end
            default: begin r = c; g = 0; b = x; end
        endcase
        m = v - c;
        r += m; g += m; b += m;
        if (norm_en_model) begin
            lum = 64'd13933 * r + 64'd46871 * g + 64'd4732 * b;
            if (lum > (64'(thr_model) << 16)) begin
                half = lum >> 1;
                r = (((r * v) << 16) + half) / lum;
                g = (((g * v) << 16) + half) / lum;
                b = (((b * v) << 16) + half) / lum;
            end
        end
        res.r = 19'(sat19(r));
        res.g = 19'(sat19(g));
        res.b = 19'(sat19(b));
        return res;
    endfunction

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_NORM_EN) norm_en_model = data[0];
        else thr_model = data[15:0];
    endtask

    // one color beat: hold valid until accepted, queue the typed result or else the prediction;
    // valid stays up afterwards, gaps and drain take it down
    task automatic send_color(input logic [15:0] hue, input logic [15:0] sat,
                              input logic [15:0] val, input bit typed,
                              input rgb_t typed_rgb);
        rgb_t pred;
        pred = hsv_convert(hue, sat, val);
        if (typed && pred != typed_rgb)
            $display("%0t directed row disagrees: table %h predictor %h",
                     $time, typed_rgb, pred);
        s_valid <= 1'b1;
        s_hue <= hue; s_saturation <= sat; s_brightness <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rgb_expected_q.insert(rgb_expected_q.size(), typed ? typed_rgb : pred);
    endtask

    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                          : $urandom_range(1, 3));
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (rgb_expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_unit();
        int k;
        k = $urandom_range(0, 15);
        if (k == 0) return 16'd32768;
        if (k == 1) return 16'($urandom_range(32769, 65535));
        if (k == 2) return 16'd0;
        return 16'($urandom_range(0, 32768));
    endfunction

    function automatic logic [15:0] rand_hue();
        if ($urandom_range(0, 9) == 0) return 16'($urandom());
        return 16'($urandom_range(0, 51472) - 25736);
    endfunction

    // result side: random stalls, checks every beat in order
    initial begin
        int n;
        rgb_t got, want;
        m_ready = 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_off) begin
                m_ready <= 1'b0;
                repeat (200) @(posedge aclk);
                hold_off = 1'b0;
            end
            n = ($urandom_range(0, 9) < 6) ? 0 :
                (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3));
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got = '{m_red, m_green, m_blue};
                if (rgb_expected_q.size() == 0) begin
                    $display("%0t unexpected beat: actual %h", $time, got);
                    errors++;
                end else begin
                    want = rgb_expected_q.pop_front();
                    if (got.r !== want.r) begin
                        $display("%0t red mismatch: expected %0d actual %0d",
                                 $time, want.r, got.r); errors++;
                    end
                    if (got.g !== want.g) begin
                        $display("%0t green mismatch: expected %0d actual %0d",
                                 $time, want.g, got.g); errors++;
                    end
                    if (got.b !== want.b) begin
                        $display("%0t blue mismatch: expected %0d actual %0d",
                                 $time, want.b, got.b); errors++;
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        row_t dir_rows[$];
        row_t rw;
        logic [31:0] thr_list[6];
        int ph;
        errors = 0; hold_off = 1'b0;
        norm_en_model = 1'b1; thr_model = THR_RESET;
        aresetn <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        paddr <= '0; pwdata <= '0;
        s_valid <= 1'b0; s_hue <= '0; s_saturation <= '0; s_brightness <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, reset register values
        dir_rows = '{
            '{16'd0, 16'd0, 16'd0, 1, '{19'd0, 19'd0, 19'd0}},      // black
            '{16'd0, 16'd0, 16'd32768, 1, '{19'd32768, 19'd32768, 19'd32768}},
            '{16'd0, 16'd65535, 16'd65535, 0, '0},                  // clamp
            '{16'd0, 16'd32768, 16'd32768, 0, '0},                  // red
            '{16'd4289, 16'd32768, 16'd32768, 0, '0},
            '{16'd8579, 16'd32768, 16'd32768, 0, '0},
            '{16'd12868, 16'd32768, 16'd32768, 0, '0},
            '{16'd17157, 16'd32768, 16'd32768, 0, '0},
            '{16'd21447, 16'd32768, 16'd32768, 0, '0},
            '{16'd25735, 16'd32768, 16'd32768, 0, '0},
            '{16'd25736, 16'd32768, 16'd32768, 0, '0},              // full turn
            '{-16'sd25736, 16'd32768, 16'd32768, 0, '0},
            '{-16'sd1, 16'd20000, 16'd30000, 0, '0},                // negative
            '{16'h7FFF, 16'd16384, 16'd16384, 0, '0},
            '{16'h8000, 16'd16384, 16'd16384, 0, '0},
            '{16'd30000, 16'd32768, 16'd1, 0, '0},                  // tiny lum
            '{16'd10000, 16'd1, 16'd40, 0, '0},
            '{16'd6000, 16'd65535, 16'd32767, 0, '0}
        };
        foreach (dir_rows[i]) begin
            rw = dir_rows[i];
            send_color(rw.hue, rw.sat, rw.val, rw.typed, rw.rgb);
            sender_gap();
        end
        drain();

        // register settings, extremes included, incl. ignored upper bits
        thr_list = '{32'd0, 32'd32768, 32'hFFFF_0021, 32'd65535, 32'd500, 32'd33};
        for (ph = 0; ph < 8; ph++) begin
            apb_write(REG_NORM_EN, (ph == 7) ? 32'hFFFF_FFFE : 32'($urandom()) | (ph % 2));
            if (ph == 2) apb_write(REG_NORM_EN, 32'd0);
            apb_write(REG_LUMA_THR, thr_list[ph % 6]);
            if (ph == 3) hold_off = 1'b1;  // receiver stalls, input backs up
            repeat (150) begin
                send_color(rand_hue(), rand_unit(), rand_unit(), 0, '0);
                if (!hold_off) sender_gap();
            end
            drain();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
